// ===== design/prrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared sizes, codes and interface types of the priority round robin
// scheduler.
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam int MAX_TASKS     = 16;
  localparam int NUM_LEVELS    = 10;
  localparam int BURST_BITS    = 16;
  localparam int ID_W          = 4;
  localparam int PRIO_W        = 4;
  localparam int POS_W         = $clog2(MAX_TASKS);
  localparam int LVL_W         = $clog2(NUM_LEVELS);
  localparam int CNT_W         = $clog2(MAX_TASKS + 1);
  localparam int QADDR_W       = LVL_W + POS_W;
  localparam int QDEPTH        = NUM_LEVELS * MAX_TASKS;
  localparam int QUANTUM_RESET = 10;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_BUSY     = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic decode_en;
    logic fetch_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic go_fetch;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/prrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_ctrl
// Sequencer: accepts a word, walks it through decode and, for a dispatch,
// the fetch step, then hands the result to the output register.
// ----------------------------------------------------------------------------
module prrs_ctrl
  import prrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = stat.go_fetch ? S_FETCH : S_OUT;
      end
      S_FETCH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.latch_in  = 1'b0;
    cmd.decode_en = 1'b0;
    cmd.fetch_en  = 1'b0;
    cmd.out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        cmd.decode_en = 1'b1;
      end
      S_FETCH: begin
        cmd.fetch_en = 1'b1;
      end
      S_OUT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/prrs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_dp
// Datapath: per-level ready queues in one memory, queue pointers, task
// bursts and busy flags, quantum register and the output register.
// ----------------------------------------------------------------------------
module prrs_dp
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  in_command,
  input  logic [ID_W-1:0]       in_task_id,
  input  logic [PRIO_W-1:0]     in_priority_req,
  input  logic [BURST_BITS-1:0] in_burst,
  input  logic                  cfg_valid,
  input  logic [BURST_BITS-1:0] cfg_quantum,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [ID_W-1:0]       out_dispatched_task,
  output logic [BURST_BITS-1:0] out_slice,
  output logic                  out_finished
);

  // latched word
  logic                  cmd_r;
  logic [ID_W-1:0]       id_r;
  logic [PRIO_W-1:0]     prio_r;
  logic [BURST_BITS-1:0] burst_r;

  logic [BURST_BITS-1:0] quantum_r;

  logic [POS_W-1:0]      lvl_head_r [NUM_LEVELS];
  logic [POS_W-1:0]      lvl_tail_r [NUM_LEVELS];
  logic [CNT_W-1:0]      lvl_cnt_r  [NUM_LEVELS];
  logic [MAX_TASKS-1:0]  slot_busy_r;
  logic [BURST_BITS-1:0] rem_burst  [MAX_TASKS];
  logic [ID_W-1:0]       queue_mem  [QDEPTH];
  logic [ID_W-1:0]       q_rdata_r;
  logic [LVL_W-1:0]      sel_lvl_r;

  // pending result
  status_t               res_status_r;
  logic [ID_W-1:0]       res_task_r;
  logic [BURST_BITS-1:0] res_slice_r;
  logic                  res_finished_r;

  // output register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ID_W-1:0]       out_task_r;
  logic [BURST_BITS-1:0] out_slice_r;
  logic                  out_finished_r;

  logic                  prio_bad;
  logic                  busy;
  logic [LVL_W-1:0]      add_lvl;
  logic                  add_ok;
  logic                  any_ready;
  logic [LVL_W-1:0]      top_lvl;
  logic                  step_pop;
  logic [POS_W-1:0]      task_pos;
  logic [BURST_BITS-1:0] cur_burst;
  logic [BURST_BITS-1:0] slice;
  logic [BURST_BITS-1:0] left;
  logic                  requeue;
  logic                  q_we;
  logic [QADDR_W-1:0]    q_waddr;
  logic [ID_W-1:0]       q_wdata;
  logic [QADDR_W-1:0]    q_raddr;

  function automatic logic [POS_W-1:0] ptr_inc(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p == POS_W'(MAX_TASKS - 1)) r = '0;
    else                            r = p + POS_W'(1);
    return r;
  endfunction

  // decode checks
  assign prio_bad = (prio_r == '0) || (prio_r > PRIO_W'(NUM_LEVELS));
  assign add_lvl  = LVL_W'(prio_r - PRIO_W'(1));
  assign busy     = slot_busy_r[id_r[POS_W-1:0]];
  assign add_ok   = cmd.decode_en && (cmd_r == CMD_ADD) && !prio_bad && !busy;
  assign step_pop = cmd.decode_en && (cmd_r == CMD_STEP) && any_ready;

  // highest non-empty level, later levels win
  always_comb begin
    any_ready = 1'b0;
    top_lvl   = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (lvl_cnt_r[i] != '0) begin
        any_ready = 1'b1;
        top_lvl   = LVL_W'(i);
      end
    end
  end

  // fetch: slice and requeue
  assign task_pos  = q_rdata_r[POS_W-1:0];
  assign cur_burst = rem_burst[task_pos];
  assign slice     = (cur_burst < quantum_r) ? cur_burst : quantum_r;
  assign left      = cur_burst - slice;
  assign requeue   = (left != '0) && (lvl_cnt_r[sel_lvl_r] < CNT_W'(MAX_TASKS));

  assign q_raddr = {top_lvl, lvl_head_r[top_lvl]};

  always_comb begin
    q_we    = 1'b0;
    q_waddr = {add_lvl, lvl_tail_r[add_lvl]};
    q_wdata = id_r;
    if (add_ok) begin
      q_we = 1'b1;
    end else if (cmd.fetch_en) begin
      q_we    = requeue;
      q_waddr = {sel_lvl_r, lvl_tail_r[sel_lvl_r]};
      q_wdata = q_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata_r <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      rem_burst[id_r[POS_W-1:0]] <= burst_r;
    end else if (cmd.fetch_en) begin
      rem_burst[task_pos] <= left;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r   <= in_command;
      id_r    <= in_task_id;
      prio_r  <= in_priority_req;
      burst_r <= in_burst;
    end
    if (step_pop) sel_lvl_r <= top_lvl;
    if (cmd.decode_en) begin
      res_task_r     <= '0;
      res_slice_r    <= '0;
      res_finished_r <= 1'b0;
      if (cmd_r == CMD_ADD) begin
        if (prio_bad)  res_status_r <= ST_BAD_PRIO;
        else if (busy) res_status_r <= ST_BUSY;
        else           res_status_r <= ST_OK;
      end else begin
        res_status_r <= any_ready ? ST_OK : ST_IDLE;
      end
    end
    if (cmd.fetch_en) begin
      res_task_r     <= ID_W'(task_pos);
      res_slice_r    <= slice;
      res_finished_r <= (left == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= BURST_BITS'(QUANTUM_RESET);
      slot_busy_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lvl_head_r[i] <= '0;
        lvl_tail_r[i] <= '0;
        lvl_cnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid) quantum_r <= cfg_quantum;
      if (add_ok) begin
        slot_busy_r[id_r[POS_W-1:0]] <= 1'b1;
        lvl_tail_r[add_lvl] <= ptr_inc(lvl_tail_r[add_lvl]);
        lvl_cnt_r[add_lvl]  <= lvl_cnt_r[add_lvl] + CNT_W'(1);
      end
      if (step_pop) begin
        lvl_head_r[top_lvl] <= ptr_inc(lvl_head_r[top_lvl]);
        lvl_cnt_r[top_lvl]  <= lvl_cnt_r[top_lvl] - CNT_W'(1);
      end
      if (cmd.fetch_en) begin
        if (requeue) begin
          lvl_tail_r[sel_lvl_r] <= ptr_inc(lvl_tail_r[sel_lvl_r]);
          lvl_cnt_r[sel_lvl_r]  <= lvl_cnt_r[sel_lvl_r] + CNT_W'(1);
        end
        if (left == '0) slot_busy_r[task_pos] <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= res_status_r;
      out_task_r     <= res_task_r;
      out_slice_r    <= res_slice_r;
      out_finished_r <= res_finished_r;
    end
  end

  assign stat.go_fetch = (cmd_r == CMD_STEP) && any_ready;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_dispatched_task = out_task_r;
  assign out_slice           = out_slice_r;
  assign out_finished        = out_finished_r;

  a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_finished_r |-> out_status_r == ST_OK)
    else $error("finished flag on a failed word");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_IDLE |->
      out_slice_r == '0 && out_task_r == '0 && !out_finished_r)
    else $error("idle word carries a grant");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_en |-> lvl_cnt_r[sel_lvl_r] < CNT_W'(MAX_TASKS))
    else $error("no room to requeue after pop");

  a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_en |-> slot_busy_r[task_pos])
    else $error("dispatched a free slot");

endmodule

// ===== design/priority_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// Ten-level priority scheduler with round robin inside each level.
// ----------------------------------------------------------------------------
// One word in gives one word out. An add, and a step that finds every queue
// empty, go from acceptance through the decode and output states back to idle;
// a dispatch step passes the fetch state as well. The output state waits while
// the output register is held by out_stall. The sequencer runs decode and then,
// for a dispatch, a fetch step behind the registered read of the queue memory.
// A new word is accepted while the previous result still waits in the output
// register. cfg_ready is always high; write the quantum only while idle.
module priority_round_robin_scheduler
  import prrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [ID_W-1:0]       in_task_id,
  input  logic [PRIO_W-1:0]     in_priority_req,
  input  logic [BURST_BITS-1:0] in_burst,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [ID_W-1:0]       out_dispatched_task,
  output logic [BURST_BITS-1:0] out_slice,
  output logic                  out_finished,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BURST_BITS-1:0] cfg_quantum
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  prrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  prrs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_command          (in_command),
    .in_task_id          (in_task_id),
    .in_priority_req     (in_priority_req),
    .in_burst            (in_burst),
    .cfg_valid           (cfg_valid),
    .cfg_quantum         (cfg_quantum),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_dispatched_task (out_dispatched_task),
    .out_slice           (out_slice),
    .out_finished        (out_finished)
  );

endmodule
